// File: hw/rtl/oat_pkg.sv
// Shared types, codes and defaults for the ordered array table engine.
package oat_pkg;

    localparam int DEPTH_DEF = 64;
    localparam int POS_W     = 7;
    localparam int CAP_W     = 7;
    localparam int WORD_W    = 32;
    localparam int IDX_OUT_W = 6;
    localparam int CNT_OUT_W = 7;

    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    localparam logic [2:0] REQ_SEARCH  = 3'd0;
    localparam logic [2:0] REQ_INSERT  = 3'd1;
    localparam logic [2:0] REQ_DELETE  = 3'd2;
    localparam logic [2:0] REQ_REVERSE = 3'd3;
    localparam logic [2:0] REQ_READ    = 3'd4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_BADPOS   = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    typedef struct packed {
        logic [2:0]              req_type;
        logic [POS_W-1:0]        position;
        logic signed [WORD_W-1:0] data_word;
    } t_request;

    typedef struct packed {
        logic [1:0]               status;
        logic [IDX_OUT_W-1:0]     found_index;
        logic signed [WORD_W-1:0] read_word;
        logic [CNT_OUT_W-1:0]     entry_count;
    } t_result;

endpackage

// File: hw/rtl/ordered_array_table_engine_top.sv
// Top level of the ordered array table engine: capacity register and core.
//
//  channel   direction  handshake                      payload
//  request   in         start & !busy                  i_request (t_request)
//  config    in         i_cfg_valid & o_cfg_ready      i_cfg_data (capacity)
//  result    out        o_result_strobe, one cycle     o_result (t_result)
//
// Sequences walk the RAM through its one write and one read port. With n live entries
// and position p: search reads from index 0 until a hit or all n are read; insert
// shifts entries p..n-1 up, if any, and then writes p; delete shifts entries above p
// down; reverse swaps pairs from both ends; read fetches one entry. The result strobe rises as busy drops.
// Rejected items, a search of an empty table and a reverse of under two entries
// keep busy low and report the cycle after they are taken.
// Reset clears the fill count and the sequencer; entries are not cleared.
// Results cannot be held off: each is shown for a single cycle.
module ordered_array_table_engine_top
    import oat_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  t_request         i_request,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CAP_W-1:0] i_cfg_data,
    output logic             o_result_strobe,
    output t_result          o_result
);

    logic [CAP_W-1:0] r_capacity;

    // the user must write capacity only while the core is idle; the block does not enforce this
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_capacity <= i_cfg_data;
        end
    end

    assign o_cfg_ready = 1'b1;

    oat_core #(
        .DEPTH (DEPTH)
    ) u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .o_busy          (busy),
        .i_request       (i_request),
        .i_capacity      (r_capacity),
        .o_result_strobe (o_result_strobe),
        .o_result        (o_result)
    );

endmodule

// File: hw/rtl/oat_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
module oat_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/oat_core.sv
// Sequencer and index unit that walk the entry RAM through its separate read and write ports.
module oat_core
    import oat_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    output logic             o_busy,
    input  t_request         i_request,
    input  logic [CAP_W-1:0] i_capacity,
    output logic             o_result_strobe,
    output t_result          o_result
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = (CW > POS_W) ? CW : POS_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_RV_RJ,
        S_RV_WI,
        S_RV_WJ,
        S_RD
    } t_state;

    t_state       r_state, n_state;
    t_request     r_req, n_req;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_left, n_left;
    logic [CW-1:0] r_ra, n_ra;
    logic [CW-1:0] r_j, n_j;
    logic [CW-1:0] r_pidx, n_pidx;
    logic          r_pend, n_pend;
    logic [WORD_W-1:0] r_tmp, n_tmp;
    logic          r_done, n_done;
    t_result       r_res, n_res;

    logic              ram_we, ram_re;
    logic [AW-1:0]     ram_waddr, ram_raddr;
    logic [WORD_W-1:0] ram_wdata, ram_rdata;

    logic [XW-1:0] pos_x, rpos_x, cnt_x, cap_x;
    logic [CW-1:0] ra_inc, ra_dec, pidx_inc, pidx_dec, cnt_inc, cnt_dec;
    logic          full;

    function automatic t_result make_res(input logic [1:0] st,
                                         input logic [IDX_OUT_W-1:0] fi,
                                         input logic [WORD_W-1:0] rw,
                                         input logic [CW-1:0] cnt);
        t_result res;
        res.status      = st;
        res.found_index = fi;
        res.read_word   = rw;
        res.entry_count = CNT_OUT_W'(cnt);
        return res;
    endfunction

    oat_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // shared index unit
    assign ra_inc   = r_ra + CW'(1);
    assign ra_dec   = r_ra - CW'(1);
    assign pidx_inc = r_pidx + CW'(1);
    assign pidx_dec = r_pidx - CW'(1);
    assign cnt_inc  = r_count + CW'(1);
    assign cnt_dec  = r_count - CW'(1);

    assign pos_x  = XW'(i_request.position);
    assign rpos_x = XW'(r_req.position);
    assign cnt_x  = XW'(r_count);
    assign cap_x  = XW'(i_capacity);
    assign full   = (cnt_x >= cap_x) || (cnt_x >= XW'(DEPTH));

    always_comb begin
        n_state   = r_state;
        n_req     = r_req;
        n_count   = r_count;
        n_left    = r_left;
        n_ra      = r_ra;
        n_j       = r_j;
        n_pidx    = r_pidx;
        n_pend    = r_pend;
        n_tmp     = r_tmp;
        n_done    = 1'b0;
        n_res     = r_res;
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = r_req.data_word;
        ram_re    = 1'b0;
        ram_raddr = '0;

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_req  = i_request;
                    n_pend = 1'b0;
                    case (i_request.req_type)
                        REQ_SEARCH: begin
                            if (r_count == '0) begin
                                n_done = 1'b1;
                                n_res  = make_res(ST_NOTFOUND, '0, '0, r_count);
                            end else begin
                                n_state = S_SCAN;
                                n_left  = r_count;
                                n_ra    = '0;
                            end
                        end
                        REQ_INSERT: begin
                            if (full) begin
                                n_done = 1'b1;
                                n_res  = make_res(ST_FULL, '0, '0, r_count);
                            end else if (pos_x > cnt_x) begin
                                n_done = 1'b1;
                                n_res  = make_res(ST_BADPOS, '0, '0, r_count);
                            end else begin
                                // shift up from the top entry down to position
                                n_state = S_SCAN;
                                n_left  = r_count - CW'(pos_x);
                                n_ra    = cnt_dec;
                            end
                        end
                        REQ_DELETE: begin
                            if (pos_x >= cnt_x) begin
                                n_done = 1'b1;
                                n_res  = make_res(ST_BADPOS, '0, '0, r_count);
                            end else begin
                                n_state = S_SCAN;
                                n_left  = cnt_dec - CW'(pos_x);
                                n_ra    = CW'(pos_x) + CW'(1);
                            end
                        end
                        REQ_REVERSE: begin
                            if (r_count < CW'(2)) begin
                                n_done = 1'b1;
                                n_res  = make_res(ST_OK, '0, '0, r_count);
                            end else begin
                                ram_re    = 1'b1;
                                ram_raddr = '0;
                                n_state   = S_RV_RJ;
                                n_ra      = '0;
                                n_j       = cnt_dec;
                                n_left    = r_count >> 1;
                            end
                        end
                        REQ_READ: begin
                            if (pos_x >= cnt_x) begin
                                n_done = 1'b1;
                                n_res  = make_res(ST_BADPOS, '0, '0, r_count);
                            end else begin
                                ram_re    = 1'b1;
                                ram_raddr = pos_x[AW-1:0];
                                n_state   = S_RD;
                            end
                        end
                        default: begin
                            n_done = 1'b1;
                            n_res  = make_res(ST_BADPOS, '0, '0, r_count);
                        end
                    endcase
                end
            end

            S_SCAN: begin
                // issue one read a cycle; use the data in the next cycle
                if (r_left != '0) begin
                    ram_re    = 1'b1;
                    ram_raddr = r_ra[AW-1:0];
                    n_ra      = (r_req.req_type == REQ_INSERT) ? ra_dec : ra_inc;
                    n_left    = r_left - CW'(1);
                    n_pend    = 1'b1;
                    n_pidx    = r_ra;
                end else begin
                    n_pend = 1'b0;
                end
                case (r_req.req_type)
                    REQ_SEARCH: begin
                        if (r_pend && (ram_rdata == r_req.data_word)) begin
                            n_state = S_IDLE;
                            n_done  = 1'b1;
                            n_res   = make_res(ST_OK, IDX_OUT_W'(r_pidx), '0, r_count);
                        end else if (!r_pend && (r_left == '0)) begin
                            n_state = S_IDLE;
                            n_done  = 1'b1;
                            n_res   = make_res(ST_NOTFOUND, '0, '0, r_count);
                        end
                    end
                    REQ_INSERT: begin
                        if (r_pend) begin
                            ram_we    = 1'b1;
                            ram_waddr = pidx_inc[AW-1:0];
                            ram_wdata = ram_rdata;
                        end else if (r_left == '0) begin
                            ram_we    = 1'b1;
                            ram_waddr = rpos_x[AW-1:0];
                            ram_wdata = r_req.data_word;
                            n_count   = cnt_inc;
                            n_state   = S_IDLE;
                            n_done    = 1'b1;
                            n_res     = make_res(ST_OK, '0, '0, cnt_inc);
                        end
                    end
                    REQ_DELETE: begin
                        if (r_pend) begin
                            ram_we    = 1'b1;
                            ram_waddr = pidx_dec[AW-1:0];
                            ram_wdata = ram_rdata;
                        end else if (r_left == '0) begin
                            n_count = cnt_dec;
                            n_state = S_IDLE;
                            n_done  = 1'b1;
                            n_res   = make_res(ST_OK, '0, '0, cnt_dec);
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end

            S_RV_RJ: begin
                ram_re    = 1'b1;
                ram_raddr = r_j[AW-1:0];
                n_tmp     = ram_rdata;
                n_state   = S_RV_WI;
            end

            S_RV_WI: begin
                ram_we    = 1'b1;
                ram_waddr = r_ra[AW-1:0];
                ram_wdata = ram_rdata;
                n_left    = r_left - CW'(1);
                n_state   = S_RV_WJ;
            end

            S_RV_WJ: begin
                // write the far end and, if a pair remains, fetch the next near entry together
                ram_we    = 1'b1;
                ram_waddr = r_j[AW-1:0];
                ram_wdata = r_tmp;
                n_ra      = ra_inc;
                n_j       = r_j - CW'(1);
                if (r_left != '0) begin
                    ram_re    = 1'b1;
                    ram_raddr = ra_inc[AW-1:0];
                    n_state   = S_RV_RJ;
                end else begin
                    n_state = S_IDLE;
                    n_done  = 1'b1;
                    n_res   = make_res(ST_OK, '0, '0, r_count);
                end
            end

            S_RD: begin
                n_state = S_IDLE;
                n_done  = 1'b1;
                n_res   = make_res(ST_OK, '0, ram_rdata, r_count);
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_pend  <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pend  <= n_pend;
            r_done  <= n_done;
        end
        r_req  <= n_req;
        r_left <= n_left;
        r_ra   <= n_ra;
        r_j    <= n_j;
        r_pidx <= n_pidx;
        r_tmp  <= n_tmp;
        r_res  <= n_res;
    end

    assign o_busy          = (r_state != S_IDLE);
    assign o_result_strobe = r_done;
    assign o_result        = r_res;

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_state == S_IDLE))
        else $error("result strobe while a sequence is still running");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("fill count above depth");

    a_count_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_done |=> (r_count == $past(r_count)) || r_done)
        else $error("fill count moved without a result");

    a_write_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (CW'(ram_waddr) <= r_count))
        else $error("entry write beyond the live range");

endmodule
